// ===== rtl/core/thri_pkg.sv =====
// thri_pkg: shared types and constants of the temperature/humidity ratio interpolator
// used by the top level and by the shared divider (thri_div)
package thri_pkg;

  localparam int TEMP_W  = 16;
  localparam int RATIO_W = 16;
  localparam int HUM_W   = 16;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;                 // entries_in_use register
  localparam int DIFF_W  = 17;                // differences of 16-bit values
  localparam int PROD_W  = 2 * DIFF_W;        // dividend of every division
  localparam int DEN_W   = DIFF_W;            // divisor of every division
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);
  localparam int RES_W   = PROD_W + 1;        // curve value plus quotient

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_ONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_TWO = 2'd2;

  // item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_SAT = 2'd1;
  localparam logic [1:0] STATUS_EQH = 2'd2;

  localparam int IN_DATA_W  = 72;  // 68 bits of fields padded to bytes
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [RATIO_W-1:0]       r2;
    logic [RATIO_W-1:0]       r1;
    logic signed [TEMP_W-1:0] temp;
  } tbl_entry_t;

endpackage

// ===== rtl/core/thri_div.sv =====
// thri_div: signed divider, quotient truncated toward zero, one quotient bit per cycle
// depends on thri_pkg for the dividend and divisor widths
module thri_div import thri_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [PROD_W-1:0] num_i,
  input  logic signed [DEN_W-1:0]  den_i,
  output logic                     done_o,
  output logic signed [PROD_W-1:0] quo_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [PROD_W-1:0]    quot_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     dmag_q;
  logic                 neg_q;

  logic [PROD_W-1:0] num_mag;
  logic [DEN_W-1:0]  den_mag;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign num_mag = num_i[PROD_W-1] ? PROD_W'(-num_i) : PROD_W'(num_i);
  assign den_mag = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quot_q[PROD_W-1]};
  assign diff  = trial - {1'b0, dmag_q};
  assign fits  = trial >= {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_mag;
      rem_q  <= '0;
      dmag_q <= den_mag;
      neg_q  <= num_i[PROD_W-1] ^ den_i[DEN_W-1];
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_q <= {quot_q[PROD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quot_q) : $signed(quot_q);

endmodule

// ===== rtl/core/temp_humidity_ratio_interpolator.sv =====
// temp_humidity_ratio_interpolator: table write and bilinear ratio query in one block
// a write beat is stored as it is accepted; an interpolating query scans up to n entries
// at one table read per cycle, then runs three divisions on the shared one-bit-per-cycle
// divider, and no new beat is accepted until its result is loaded; a clamped query skips
// the two temperature divisions, equal reference humidities skip the last one
// a waiting result sits in the output register; reset clears control and config, not the table
module temp_humidity_ratio_interpolator import thri_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // entry_index[3:0], temperature[19:4], humidity[35:20],
  // ratio_curve_one[51:36], ratio_curve_two[67:52], zero pad[71:68]
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,
  // func[0]
  input  logic                    s_axis_tuser,
  // output stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // ratio[15:0]
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [1:0]              m_axis_tuser
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_HUM    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  localparam logic [1:0] STEP_ONE = 2'd0;
  localparam logic [1:0] STEP_TWO = 2'd1;
  localparam logic [1:0] STEP_HUM = 2'd2;

  // input fields
  logic                       in_func;
  logic [IDX_W-1:0]           in_idx;
  logic signed [TEMP_W-1:0]   in_temp;
  logic signed [HUM_W-1:0]    in_hum;
  logic [RATIO_W-1:0]         in_r1;
  logic [RATIO_W-1:0]         in_r2;

  assign in_func = s_axis_tuser;
  assign in_idx  = s_axis_tdata[3:0];
  assign in_temp = s_axis_tdata[19:4];
  assign in_hum  = s_axis_tdata[35:20];
  assign in_r1   = s_axis_tdata[51:36];
  assign in_r2   = s_axis_tdata[67:52];

  // config registers
  logic [CNT_W-1:0]        cfg_entries_q;
  logic signed [HUM_W-1:0] hum_one_q;
  logic signed [HUM_W-1:0] hum_two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_entries_q <= CNT_W'(1);
      hum_one_q     <= '0;
      hum_two_q     <= HUM_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENTRIES: cfg_entries_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_HUM_ONE: hum_one_q     <= cfg_wdata_i;
        CFG_HUM_TWO: hum_two_q     <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // control state
  logic [2:0]    state_q, state_d;
  logic [1:0]    step_q, step_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;

  // payload registers
  logic signed [TEMP_W-1:0] t_q;
  logic signed [HUM_W-1:0]  h_q;
  tbl_entry_t               prev_q, cur_q, rd_q;
  logic [RATIO_W-1:0]       r1_q, r2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DEN_W-1:0]  den_q;
  logic [RATIO_W-1:0]       res_q;
  logic [1:0]               status_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [1:0]            out_user_q;

  logic s_fire, wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] n_sel;

  tbl_entry_t mem [TABLE_DEPTH];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s_fire && (in_func == FUNC_WRITE) && (32'(in_idx) < TABLE_DEPTH);

  // effective entry count: zero reads as one, too many saturates to the depth
  always_comb begin
    if (cfg_entries_q == '0) begin
      n_sel = CW'(1);
    end else if (32'(cfg_entries_q) > TABLE_DEPTH) begin
      n_sel = CW'(TABLE_DEPTH);
    end else begin
      n_sel = CW'(cfg_entries_q);
    end
  end

  // scan compare on the entry just read
  logic scan_gt, scan_last;
  assign scan_gt   = t_q > rd_q.temp;
  assign scan_last = (CW'(idx_q) + CW'(1)) == n_q;

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(in_idx)] <= '{r2: in_r2, r1: in_r1, temp: in_temp};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // multiplier operands per step
  logic signed [DIFF_W-1:0] mul_a, mul_b, mul_den;
  always_comb begin
    case (step_q)
      STEP_ONE: begin
        mul_a   = $signed({1'b0, cur_q.r1}) - $signed({1'b0, prev_q.r1});
        mul_b   = $signed({t_q[TEMP_W-1], t_q}) - $signed({cur_q.temp[TEMP_W-1], cur_q.temp});
        mul_den = $signed({cur_q.temp[TEMP_W-1], cur_q.temp})
                - $signed({prev_q.temp[TEMP_W-1], prev_q.temp});
      end
      STEP_TWO: begin
        mul_a   = $signed({1'b0, cur_q.r2}) - $signed({1'b0, prev_q.r2});
        mul_b   = $signed({t_q[TEMP_W-1], t_q}) - $signed({cur_q.temp[TEMP_W-1], cur_q.temp});
        mul_den = $signed({cur_q.temp[TEMP_W-1], cur_q.temp})
                - $signed({prev_q.temp[TEMP_W-1], prev_q.temp});
      end
      default: begin
        mul_a   = $signed({h_q[HUM_W-1], h_q}) - $signed({hum_one_q[HUM_W-1], hum_one_q});
        mul_b   = $signed({1'b0, r2_q}) - $signed({1'b0, r1_q});
        mul_den = $signed({hum_two_q[HUM_W-1], hum_two_q})
                - $signed({hum_one_q[HUM_W-1], hum_one_q});
      end
    endcase
  end

  // shared divider
  logic                     div_start, div_done;
  logic signed [PROD_W-1:0] div_quo;

  assign div_start = (state_q == S_DSTART);

  thri_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // humidity step result with saturation
  logic signed [RES_W-1:0] hum_res;
  logic [RATIO_W-1:0]      sat_res;
  logic [1:0]              sat_status;

  assign hum_res = $signed({{(RES_W-RATIO_W){1'b0}}, r1_q})
                 + $signed({div_quo[PROD_W-1], div_quo});

  always_comb begin
    if (hum_res < 0) begin
      sat_res    = '0;
      sat_status = STATUS_SAT;
    end else if (hum_res > $signed(RES_W'(65535))) begin
      sat_res    = '1;
      sat_status = STATUS_SAT;
    end else begin
      sat_res    = hum_res[RATIO_W-1:0];
      sat_status = STATUS_OK;
    end
  end

  logic out_load;
  assign out_load = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    n_d     = n_q;
    rd_en   = 1'b0;
    rd_addr = idx_q + AW'(1);
    case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        if (s_fire && (in_func == FUNC_QUERY)) begin
          rd_en   = 1'b1;
          idx_d   = '0;
          n_d     = n_sel;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_gt && !scan_last) begin
          rd_en = 1'b1;
          idx_d = idx_q + AW'(1);
        end else if (scan_gt || (idx_q == '0)) begin
          state_d = S_HUM;
        end else begin
          step_d  = STEP_ONE;
          state_d = S_MUL;
        end
      end
      S_MUL:    state_d = S_DSTART;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          case (step_q)
            STEP_ONE: begin
              step_d  = STEP_TWO;
              state_d = S_MUL;
            end
            STEP_TWO: state_d = S_HUM;
            default:  state_d = S_RESULT;
          endcase
        end
      end
      S_HUM: begin
        if (hum_one_q == hum_two_q) begin
          state_d = S_RESULT;
        end else begin
          step_d  = STEP_HUM;
          state_d = S_MUL;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_ONE;
      idx_q       <= '0;
      n_q         <= CW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      t_q <= in_temp;
      h_q <= in_hum;
    end
    case (state_q)
      S_SCAN: begin
        if (scan_gt && !scan_last) begin
          prev_q <= rd_q;
        end else if (scan_gt || (idx_q == '0)) begin
          // clamp to the first or last entry
          r1_q <= rd_q.r1;
          r2_q <= rd_q.r2;
        end else begin
          cur_q <= rd_q;
        end
      end
      S_MUL: begin
        prod_q <= mul_a * mul_b;
        den_q  <= mul_den;
      end
      S_DWAIT: begin
        if (div_done) begin
          case (step_q)
            STEP_ONE: r1_q <= cur_q.r1 + div_quo[RATIO_W-1:0];
            STEP_TWO: r2_q <= cur_q.r2 + div_quo[RATIO_W-1:0];
            default: begin
              res_q    <= sat_res;
              status_q <= sat_status;
            end
          endcase
        end
      end
      S_HUM: begin
        if (hum_one_q == hum_two_q) begin
          res_q    <= r1_q;
          status_q <= STATUS_EQH;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= res_q;
      out_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
